// File: design/srm_pkg.sv
`timescale 1ns / 1ps
package srm_pkg;
    localparam int MIX_FACTOR_DEF    = 1;
    localparam int MAX_LOG2_COST_DEF = 10;
    localparam int SUB_WORDS         = 8;
    localparam int ROUNDS            = 8;
    localparam logic [3:0] LOG2_COST_RESET = 4'd10;
    localparam logic [0:0] REG_LOG2_COST   = 1'b0;

    typedef enum logic [2:0] {
        t_st_load,
        t_st_write,
        t_st_fetch,
        t_st_mix,
        t_st_emit
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load_word;
        logic tbl_write;
        logic xor_tbl;
        logic core_start;
        logic emit;
        logic phase2;
    } t_ctrl;

    // status from datapath to controller
    typedef struct packed {
        logic core_done;
        logic mix_done;
    } t_stat;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int c);
        rotl = (v << c) | (v >> (32 - c));
    endfunction
endpackage

// File: design/srm_ram.sv
`timescale 1ns / 1ps
module srm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: design/srm_ctrl.sv
`timescale 1ns / 1ps
module srm_ctrl import srm_pkg::*; #(
    parameter int MIX_FACTOR    = MIX_FACTOR_DEF,
    parameter int MAX_LOG2_COST = MAX_LOG2_COST_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [3:0]                        i_log2_cost,
    input  t_stat                             i_stat,
    output t_ctrl                             o_ctrl,
    output logic [$clog2(16*MIX_FACTOR)-1:0]  o_widx,
    output logic [MAX_LOG2_COST:0]            o_iter,
    output logic [MAX_LOG2_COST-1:0]          o_nmask,
    output logic                              o_busy,
    output logic                              o_last
);
    localparam int BW = 16 * MIX_FACTOR;
    localparam int WB = $clog2(BW);

    t_state                 r_state, n_state;
    logic [WB-1:0]          r_widx, n_widx;
    logic [MAX_LOG2_COST:0] r_iter, n_iter;
    logic                   r_ph2, n_ph2;
    logic [MAX_LOG2_COST-1:0] r_mask, n_mask;
    logic                   r_mixing, n_mixing;
    logic [4:0]             lc_sat;
    logic                   w_iter_end, w_widx_end;

    assign w_widx_end = (r_widx == WB'(BW - 1));
    assign w_iter_end = (r_iter[MAX_LOG2_COST-1:0] == r_mask);

    // clamp cost to its legal range
    always_comb begin
        lc_sat = {1'b0, i_log2_cost};
        if (lc_sat < 5'd1) lc_sat = 5'd1;
        if (lc_sat > 5'(MAX_LOG2_COST)) lc_sat = 5'(MAX_LOG2_COST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= t_st_load;
            r_widx   <= '0;
            r_iter   <= '0;
            r_ph2    <= 1'b0;
            r_mask   <= '0;
            r_mixing <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_widx   <= n_widx;
            r_iter   <= n_iter;
            r_ph2    <= n_ph2;
            r_mask   <= n_mask;
            r_mixing <= n_mixing;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_widx   = r_widx;
        n_iter   = r_iter;
        n_ph2    = r_ph2;
        n_mask   = r_mask;
        n_mixing = r_mixing;
        unique case (r_state)
            t_st_load: begin
                if (i_start) begin
                    n_widx = r_widx + 1'b1;
                    if (w_widx_end) begin
                        n_widx  = '0;
                        n_iter  = '0;
                        n_ph2   = 1'b0;
                        n_mask  = MAX_LOG2_COST'((1 << lc_sat) - 1);
                        n_state = t_st_write;
                    end
                end
            end
            t_st_write: begin
                n_widx = r_widx + 1'b1;
                if (w_widx_end) begin
                    n_widx   = '0;
                    n_mixing = 1'b0;
                    n_state  = t_st_mix;
                end
            end
            t_st_fetch: begin
                // issue one read a word, then wait in fetch while the last word's xor lands
                if (r_mixing) begin
                    n_mixing = 1'b0;
                    n_state  = t_st_mix;
                end else begin
                    n_widx = r_widx + 1'b1;
                    if (w_widx_end) begin
                        n_widx   = '0;
                        n_mixing = 1'b1;
                    end
                end
            end
            t_st_mix: begin
                n_mixing = 1'b1;
                if (i_stat.mix_done) begin
                    n_mixing = 1'b0;
                    n_iter   = r_iter + 1'b1;
                    if (w_iter_end) begin
                        n_iter = '0;
                        if (r_ph2) begin
                            n_state = t_st_emit;
                        end else begin
                            n_ph2   = 1'b1;
                            n_state = t_st_fetch;
                        end
                    end else begin
                        n_state = r_ph2 ? t_st_fetch : t_st_write;
                    end
                end
            end
            t_st_emit: begin
                n_widx = r_widx + 1'b1;
                if (w_widx_end) begin
                    n_widx  = '0;
                    n_state = t_st_load;
                end
            end
            default: n_state = t_st_load;
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl = '0;
        o_ctrl.phase2 = r_ph2;
        unique case (r_state)
            t_st_load:  o_ctrl.load_word = i_start;
            t_st_write: o_ctrl.tbl_write = 1'b1;
            t_st_fetch: o_ctrl.xor_tbl   = !r_mixing;
            t_st_mix:   o_ctrl.core_start = !r_mixing;
            t_st_emit:  o_ctrl.emit      = 1'b1;
            default:    o_ctrl = '0;
        endcase
    end

    assign o_widx  = r_widx;
    assign o_iter  = r_iter;
    assign o_nmask = r_mask;
    assign o_busy  = (r_state != t_st_load);
    assign o_last  = w_widx_end;
endmodule

// File: design/srm_dp.sv
`timescale 1ns / 1ps
module srm_dp import srm_pkg::*; #(
    parameter int MIX_FACTOR    = MIX_FACTOR_DEF,
    parameter int MAX_LOG2_COST = MAX_LOG2_COST_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_ctrl                             i_ctrl,
    input  logic [$clog2(16*MIX_FACTOR)-1:0]  i_widx,
    input  logic [MAX_LOG2_COST:0]            i_iter,
    input  logic [MAX_LOG2_COST-1:0]          i_nmask,
    input  logic [63:0]                       i_word_value,
    output t_stat                             o_stat,
    output logic [63:0]                       o_word
);
    localparam int BW    = 16 * MIX_FACTOR;
    localparam int WB    = $clog2(BW);
    localparam int NSUB  = 2 * MIX_FACTOR;
    localparam int SB    = (NSUB > 1) ? $clog2(NSUB) : 1;
    localparam int DEPTH = (1 << MAX_LOG2_COST) * BW;
    localparam int AB    = MAX_LOG2_COST + WB;

    logic [63:0] r_blk [BW];
    logic [63:0] r_dst [BW];
    logic [31:0] r_x   [16];
    logic [31:0] r_in  [16];
    logic [2:0]  r_rnd;
    logic        r_run;
    logic        r_mdone;
    logic [SB-1:0] r_sub;
    logic [MAX_LOG2_COST-1:0] w_idx, w_idx_now, r_idx;
    logic [AB-1:0] w_waddr, w_raddr;
    logic [63:0] w_rdata;
    logic [WB-1:0] r_fidx;
    logic        r_fval;
    logic [31:0] y [16];
    logic [31:0] z [16];
    logic [SB-1:0] w_pos;
    logic        w_core_end;

    // table index from the first word of the last sub-block; hold it while the xor lands
    assign w_idx_now = r_blk[(NSUB-1)*SUB_WORDS][MAX_LOG2_COST-1:0] & i_nmask;
    assign w_idx     = r_fval ? r_idx : w_idx_now;
    assign w_waddr = {i_iter[MAX_LOG2_COST-1:0], i_widx};
    assign w_raddr = {w_idx, i_widx};

    srm_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.tbl_write),
        .i_waddr (w_waddr),
        .i_wdata (r_blk[i_widx]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // quarter round; the core alternates column and row rounds on the round count's parity
    function automatic void qr(inout logic [31:0] a, b, c, d);
        b = b ^ rotl(a + d, 7);
        c = c ^ rotl(b + a, 9);
        d = d ^ rotl(c + b, 13);
        a = a ^ rotl(d + c, 18);
    endfunction

    always_comb begin
        for (int k = 0; k < 16; k++) y[k] = r_x[k];
        if (!r_rnd[0]) begin
            qr(y[0], y[4], y[8], y[12]);
            qr(y[5], y[9], y[13], y[1]);
            qr(y[10], y[14], y[2], y[6]);
            qr(y[15], y[3], y[7], y[11]);
        end else begin
            qr(y[0], y[1], y[2], y[3]);
            qr(y[5], y[6], y[7], y[4]);
            qr(y[10], y[11], y[8], y[9]);
            qr(y[15], y[12], y[13], y[14]);
        end
        for (int k = 0; k < 16; k++) z[k] = y[k] + r_in[k];
    end

    assign w_pos      = r_sub[0] ? SB'(MIX_FACTOR + (r_sub >> 1)) : SB'(r_sub >> 1);
    assign w_core_end = r_run && (r_rnd == 3'(ROUNDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_rnd   <= '0;
            r_sub   <= '0;
            r_fval  <= 1'b0;
            r_mdone <= 1'b0;
        end else begin
            r_fval  <= i_ctrl.xor_tbl;
            r_mdone <= w_core_end && (r_sub == SB'(NSUB - 1));
            if (i_ctrl.core_start) begin
                r_run <= 1'b1;
                r_rnd <= '0;
                r_sub <= '0;
            end else if (r_run) begin
                r_rnd <= r_rnd + 1'b1;
                if (w_core_end) begin
                    r_sub <= r_sub + 1'b1;
                    if (r_sub == SB'(NSUB - 1)) r_run <= 1'b0;
                end
            end
        end
    end

    // block storage, table xor, core load and result placement
    always_ff @(posedge i_clk) begin
        r_fidx <= i_widx;
        if (!r_fval) r_idx <= w_idx_now;
        if (i_ctrl.load_word) r_blk[i_widx] <= i_word_value;
        if (r_fval) r_blk[r_fidx] <= r_blk[r_fidx] ^ w_rdata;
        if (i_ctrl.core_start) begin
            for (int k = 0; k < 8; k++) begin
                {r_in[2*k+1], r_in[2*k]} <= r_blk[(NSUB-1)*SUB_WORDS+k] ^ r_blk[k];
                {r_x[2*k+1], r_x[2*k]}   <= r_blk[(NSUB-1)*SUB_WORDS+k] ^ r_blk[k];
            end
        end else if (r_run) begin
            if (w_core_end) begin
                for (int k = 0; k < 8; k++) begin
                    r_dst[w_pos*SUB_WORDS+k] <= {z[2*k+1], z[2*k]};
                    if (r_sub != SB'(NSUB - 1)) begin
                        {r_in[2*k+1], r_in[2*k]} <= {z[2*k+1], z[2*k]}
                            ^ r_blk[(r_sub+1)*SUB_WORDS+k];
                        {r_x[2*k+1], r_x[2*k]}   <= {z[2*k+1], z[2*k]}
                            ^ r_blk[(r_sub+1)*SUB_WORDS+k];
                    end
                end
            end else begin
                for (int k = 0; k < 16; k++) r_x[k] <= y[k];
            end
        end
        if (o_stat.mix_done) begin
            for (int k = 0; k < BW; k++) r_blk[k] <= r_dst[k];
        end
    end

    assign o_stat.core_done = w_core_end;
    assign o_stat.mix_done  = r_mdone;
    assign o_word = r_blk[i_widx];
endmodule

// File: design/scrypt_romix_salsa20_8.sv
// Sequence: 16R load words; then N passes, each writing 16R words to the table and
// running a BlockMix of 2R cores, then N passes, each fetching and xoring 16R table
// words before the same BlockMix; then 16R result words. Only one block at a time:
// a new block is loaded only after the last result word has gone out.
// Reset: synchronous, active low; table contents undefined until written.
// Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
module scrypt_romix_salsa20_8 import srm_pkg::*; #(
    parameter int MIX_FACTOR    = MIX_FACTOR_DEF,
    parameter int MAX_LOG2_COST = MAX_LOG2_COST_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_word_value,
    output logic        o_valid,
    output logic [63:0] o_result_word,
    output logic        o_result_last
);
    t_ctrl w_ctrl;
    t_stat w_stat;
    logic [$clog2(16*MIX_FACTOR)-1:0] w_widx;
    logic [MAX_LOG2_COST:0]   w_iter;
    logic [MAX_LOG2_COST-1:0] w_nmask;
    logic [3:0] r_cost;
    logic       w_busy, w_last;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost <= LOG2_COST_RESET;
        end else if (psel && penable && pwrite && paddr == 2'b00) begin
            r_cost <= pwdata[3:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr == 2'b00) ? {28'd0, r_cost} : 32'd0;

    srm_ctrl #(.MIX_FACTOR(MIX_FACTOR), .MAX_LOG2_COST(MAX_LOG2_COST)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_log2_cost(r_cost),
        .i_stat(w_stat), .o_ctrl(w_ctrl), .o_widx(w_widx), .o_iter(w_iter),
        .o_nmask(w_nmask), .o_busy(w_busy), .o_last(w_last)
    );

    srm_dp #(.MIX_FACTOR(MIX_FACTOR), .MAX_LOG2_COST(MAX_LOG2_COST)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(w_ctrl), .i_widx(w_widx),
        .i_iter(w_iter), .i_nmask(w_nmask), .i_word_value(i_word_value),
        .o_stat(w_stat), .o_word(o_result_word)
    );

    assign busy          = w_busy;
    assign o_valid       = w_ctrl.emit;
    assign o_result_last = w_ctrl.emit && w_last;
endmodule

// File: design/srm_check.sv
`timescale 1ns / 1ps
module srm_check (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_result_last
);
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_last |-> o_valid) else $error("last without strobe");
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result while idle");
    a_last_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_last |=> !busy) else $error("busy after last word");
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid) else $error("result right after a loaded word");
endmodule

bind scrypt_romix_salsa20_8 srm_check u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_result_last(o_result_last)
);

// File: dv/scrypt_romix_salsa20_8_test.sv
`timescale 1ns / 1ps
module scrypt_romix_salsa20_8_test;
    import srm_pkg::*;

    typedef logic [15:0][31:0] salsa_state_t;
    typedef logic [7:0][63:0]  sub_block_t;
    typedef logic [15:0][63:0] mix_block_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [63:0] i_word_value;
    logic        o_valid;
    logic [63:0] o_result_word;
    logic        o_result_last;

    scrypt_romix_salsa20_8 uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .i_word_value(i_word_value),
        .o_valid(o_valid), .o_result_word(o_result_word),
        .o_result_last(o_result_last)
    );

    // predictor state
    logic [3:0]  cost_reg;
    int          words_loaded;
    mix_block_t  gather_block;
    mix_block_t  scratch_table [0:1023];
    logic [63:0] word_queue [$];
    logic        last_queue [$];

    int  fail_count;
    int  words_sent;
    int  words_checked;
    int  blocks_done;
    int  sender_idle_pct;
    longint cycle_count;

    localparam longint CYCLE_LIMIT = 4000000;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rot_left(logic [31:0] v, int c);
        logic [63:0] twice;
        twice = {v, v};
        return twice[63 - c -: 32];
    endfunction

    function automatic salsa_state_t quarter_round(salsa_state_t x, int a, int b, int c, int d);
        x[b] = x[b] ^ rot_left(x[a] + x[d], 7);
        x[c] = x[c] ^ rot_left(x[b] + x[a], 9);
        x[d] = x[d] ^ rot_left(x[c] + x[b], 13);
        x[a] = x[a] ^ rot_left(x[d] + x[c], 18);
        return x;
    endfunction

    function automatic sub_block_t salsa8_core(sub_block_t b);
        salsa_state_t init_st;
        salsa_state_t x;
        sub_block_t   res;
        for (int k = 0; k < 8; k++) begin
            init_st[2 * k]     = b[k][31:0];
            init_st[2 * k + 1] = b[k][63:32];
        end
        x = init_st;
        for (int r = 0; r < 4; r++) begin
            x = quarter_round(x, 0, 4, 8, 12);
            x = quarter_round(x, 5, 9, 13, 1);
            x = quarter_round(x, 10, 14, 2, 6);
            x = quarter_round(x, 15, 3, 7, 11);
            x = quarter_round(x, 0, 1, 2, 3);
            x = quarter_round(x, 5, 6, 7, 4);
            x = quarter_round(x, 10, 11, 8, 9);
            x = quarter_round(x, 15, 12, 13, 14);
        end
        for (int k = 0; k < 8; k++)
            res[k] = {init_st[2 * k + 1] + x[2 * k + 1], init_st[2 * k] + x[2 * k]};
        return res;
    endfunction

    // chain the cores from the last sub-block; even result low, odd high
    function automatic mix_block_t block_mix(mix_block_t src);
        sub_block_t acc;
        mix_block_t dst;
        acc = src[15:8];
        acc = salsa8_core(acc ^ src[7:0]);
        dst[7:0] = acc;
        acc = salsa8_core(acc ^ src[15:8]);
        dst[15:8] = acc;
        return dst;
    endfunction

    // full memory-hard mix, then queue the sixteen output words
    task automatic romix_expect(mix_block_t blk);
        int lc;
        int n;
        int idx;
        lc = cost_reg;
        if (lc < 1) lc = 1;
        if (lc > MAX_LOG2_COST_DEF) lc = MAX_LOG2_COST_DEF;
        n = 1 << lc;
        for (int i = 0; i < n; i++) begin
            scratch_table[i] = blk;
            blk = block_mix(blk);
        end
        for (int i = 0; i < n; i++) begin
            idx = int'(blk[8] & 64'(n - 1));
            blk = block_mix(blk ^ scratch_table[idx]);
        end
        for (int k = 0; k < 16; k++) begin
            word_queue.push_back(blk[k]);
            last_queue.push_back(k == 15);
        end
    endtask

    // send one word; hold start until the block takes it
    task automatic send_word(logic [63:0] w);
        start        <= 1'b1;
        i_word_value <= w;
        do @(posedge i_clk); while (busy);
        words_sent++;
        gather_block[words_loaded] = w;
        words_loaded++;
        if (words_loaded == 16) begin
            words_loaded = 0;
            blocks_done++;
            romix_expect(gather_block);
        end
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
    endtask

    task automatic send_block(int kind);
        logic [63:0] w;
        for (int k = 0; k < 16; k++) begin
            case (kind)
                0: w = 64'd0;
                1: w = '1;
                2: w = (k[0]) ? 64'h5555_5555_5555_5555 : 64'hAAAA_AAAA_AAAA_AAAA;
                default: w = {$urandom, $urandom};
            endcase
            send_word(w);
        end
    endtask

    // write the cost register over the APB port
    task automatic write_cost(logic [3:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'(REG_LOG2_COST);
        pwdata  <= {28'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        cost_reg = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drop start and wait until every queued word has come out
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (word_queue.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_reset_cost;
        sender_idle_pct = 0;
        send_block(0);
        drain();
    endtask

    task automatic test_cost_extremes;
        write_cost(4'd15);
        send_block(1);
        drain();
        write_cost(4'd0);
        send_block(2);
        drain();
        write_cost(4'd1);
        send_block(1);
        drain();
    endtask

    task automatic test_change_while_loading;
        write_cost(4'd2);
        for (int k = 0; k < 8; k++) send_word({$urandom, $urandom});
        start <= 1'b0;
        @(posedge i_clk);
        write_cost(4'd3);
        for (int k = 0; k < 8; k++) send_word({$urandom, $urandom});
        drain();
    endtask

    task automatic test_random_blocks(int n_blocks, int idle_pct);
        sender_idle_pct = idle_pct;
        for (int b = 0; b < n_blocks; b++) begin
            if (b % 3 == 0) begin
                write_cost(4'($urandom_range(4, 0)));
            end
            send_block(3);
            if (b % 3 == 2) drain();
        end
        drain();
    endtask

    // compare each output word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (word_queue.size() == 0) begin
                $error("result_word: unexpected word %h", o_result_word);
                fail_count++;
            end else begin
                if (o_result_word !== word_queue[0]) begin
                    $error("result_word: expected %h, got %h", word_queue[0], o_result_word);
                    fail_count++;
                end
                if (o_result_last !== last_queue[0]) begin
                    $error("result_last: expected %b, got %b", last_queue[0], o_result_last);
                    fail_count++;
                end
                void'(word_queue.pop_front());
                void'(last_queue.pop_front());
                words_checked++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        cycle_count     = 0;
        fail_count      = 0;
        words_sent      = 0;
        words_checked   = 0;
        blocks_done     = 0;
        words_loaded    = 0;
        sender_idle_pct = 0;
        cost_reg        = LOG2_COST_RESET;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        start           = 1'b0;
        i_word_value    = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_cost();
        test_cost_extremes();
        test_change_while_loading();
        test_random_blocks(5, 0);
        test_random_blocks(4, 58);
        test_random_blocks(4, 20);

        repeat (20) @(posedge i_clk);
        $display("Sent %0d words in %0d blocks; checked %0d output words.",
                 words_sent, blocks_done, words_checked);
        $display("Costs from 0 to 15, mid-load register change, sender gaps of 0, 58 and 20.");
        if (fail_count == 0 && word_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// File: filelist.f
design/srm_pkg.sv
design/srm_ram.sv
design/srm_ctrl.sv
design/srm_dp.sv
design/scrypt_romix_salsa20_8.sv
design/srm_check.sv
dv/scrypt_romix_salsa20_8_test.sv
